// ----- hw/rtl/dsts_pkg.sv -----
// Shared types, codes and step tables for the dual stepper timed sequencer.
package dsts_pkg;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int SPEED_W         = 16;
    localparam int PORT_W          = 8;
    localparam int NUM_CH          = 3;

    typedef enum logic [1:0] {
        FUNC_TICK     = 2'd0,
        FUNC_STRAIGHT = 2'd1,
        FUNC_RIGHT    = 2'd2,
        FUNC_LEFT     = 2'd3
    } func_t;

    // Channel numbers, also the bit positions in channels_fired
    localparam int CH_STRAIGHT = 0;
    localparam int CH_RIGHT    = 1;
    localparam int CH_LEFT     = 2;

    // Straight index moves two phases per step
    localparam logic [3:0] STRAIGHT_STEP = 4'd2;
    localparam logic [3:0] STRAIGHT_FWD_LIMIT = 4'd7;
    localparam logic [2:0] STRAIGHT_REV_WRAP = 3'd6;

    localparam logic [3:0] PHASE_TAB [8] = '{
        4'h5, 4'h4, 4'h6, 4'h2, 4'hA, 4'h8, 4'h9, 4'h1
    };
    localparam logic [PORT_W-1:0] RIGHT_TAB [4] = '{8'h56, 8'h9A, 8'hA9, 8'h65};
    localparam logic [PORT_W-1:0] LEFT_TAB  [4] = '{8'h65, 8'hA9, 8'h9A, 8'h56};

    typedef struct packed {
        func_t               func;
        logic [SPEED_W-1:0]  speed;
    } cmd_t;

    typedef struct packed {
        logic [PORT_W-1:0]   port_value;
        logic                port_written;
        logic [NUM_CH-1:0]   channels_fired;
    } res_t;

endpackage

// ----- hw/rtl/dsts_cmd_if.sv -----
// Valid/ready channel carrying one request item (func, speed).
interface dsts_cmd_if;
    logic           valid;
    logic           ready;
    dsts_pkg::cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/dsts_res_if.sv -----
// Valid/ready channel carrying one result item (port value and fire flags).
interface dsts_res_if;
    logic           valid;
    logic           ready;
    dsts_pkg::res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/dsts_core.sv -----
// Tick counter, three output-compare channels and the stepper port state.
module dsts_core #(
    parameter int TIMER_WIDTH = dsts_pkg::TIMER_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  dsts_pkg::cmd_t item,
    output dsts_pkg::res_t result
);
    import dsts_pkg::*;

    localparam int TW = TIMER_WIDTH;

    logic [TW-1:0]     tick_reg, tick_next, tick_inc;
    logic [TW-1:0]     cmp_reg  [NUM_CH];
    logic [TW-1:0]     cmp_next [NUM_CH];
    logic [TW-1:0]     per_reg  [NUM_CH];
    logic [TW-1:0]     per_next [NUM_CH];
    logic [NUM_CH-1:0] en_reg, en_next;
    logic [2:0]        sidx_reg, sidx_next;
    logic              srev_reg, srev_next;
    logic [1:0]        ridx_reg, ridx_next;
    logic [1:0]        lidx_reg, lidx_next;
    logic [PORT_W-1:0] port_reg, port_next;

    logic [NUM_CH-1:0] hit;
    logic [NUM_CH-1:0] arm_sel;
    logic [TW-1:0]     arm_per;
    logic [SPEED_W:0]  speed_ext;
    logic [SPEED_W:0]  speed_mag;
    logic [31:0]       mag_wide;
    logic [31:0]       sext_wide;
    logic [3:0]        sidx_fwd;
    logic [3:0]        phase;

    assign tick_inc  = TW'(tick_reg + 1'b1);
    assign speed_ext = {item.speed[SPEED_W-1], item.speed};
    assign speed_mag = speed_ext[SPEED_W] ? (~speed_ext + 1'b1) : speed_ext;
    assign mag_wide  = 32'(speed_mag);
    assign sext_wide = 32'(signed'(item.speed));
    assign sidx_fwd  = {1'b0, sidx_reg} + STRAIGHT_STEP;
    assign phase     = PHASE_TAB[sidx_reg];

    always_comb
    begin
        arm_sel = '0;
        arm_per = sext_wide[TW-1:0];
        case (item.func)
            FUNC_TICK:
            begin
                arm_sel = '0;
            end
            FUNC_STRAIGHT:
            begin
                arm_sel[CH_STRAIGHT] = 1'b1;
                arm_per = mag_wide[TW-1:0];
            end
            FUNC_RIGHT:
            begin
                arm_sel[CH_RIGHT] = 1'b1;
            end
            FUNC_LEFT:
            begin
                arm_sel[CH_LEFT] = 1'b1;
            end
            default:
            begin
                arm_sel = '0;
            end
        endcase
    end

    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            hit[ch] = (item.func == FUNC_TICK) && en_reg[ch] && (cmp_reg[ch] == tick_inc);
        end
    end

    always_comb
    begin
        tick_next = tick_reg;
        en_next   = en_reg;
        sidx_next = sidx_reg;
        srev_next = srev_reg;
        ridx_next = ridx_reg;
        lidx_next = lidx_reg;
        port_next = port_reg;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            cmp_next[ch] = cmp_reg[ch];
            per_next[ch] = per_reg[ch];
        end

        if (item.func == FUNC_TICK) begin
            tick_next = tick_inc;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                if (hit[ch]) begin
                    cmp_next[ch] = TW'(cmp_reg[ch] + per_reg[ch]);
                end
            end
            // advance each table that fired; highest channel owns the port
            if (hit[CH_STRAIGHT]) begin
                port_next = {phase, phase};
                if (srev_reg) begin
                    sidx_next = (sidx_reg < 3'(STRAIGHT_STEP)) ? STRAIGHT_REV_WRAP
                                                             : 3'(sidx_reg - 3'(STRAIGHT_STEP));
                end
                else begin
                    sidx_next = (sidx_fwd >= STRAIGHT_FWD_LIMIT) ? 3'd0 : sidx_fwd[2:0];
                end
            end
            if (hit[CH_RIGHT]) begin
                port_next = RIGHT_TAB[ridx_reg];
                ridx_next = 2'(ridx_reg + 1'b1);
            end
            if (hit[CH_LEFT]) begin
                port_next = LEFT_TAB[lidx_reg];
                lidx_next = 2'(lidx_reg + 1'b1);
            end
        end
        else begin
            if (arm_sel[CH_STRAIGHT]) begin
                srev_next = item.speed[SPEED_W-1];
            end
            for (int ch = 0; ch < NUM_CH; ch++) begin
                if (arm_sel[ch]) begin
                    en_next[ch]  = 1'b1;
                    per_next[ch] = arm_per;
                    cmp_next[ch] = TW'(tick_reg + arm_per);
                end
            end
        end
    end

    assign result.port_value     = port_next;
    assign result.port_written   = |hit;
    assign result.channels_fired = hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tick_reg <= '0;
            en_reg   <= '0;
            sidx_reg <= '0;
            srev_reg <= 1'b0;
            ridx_reg <= '0;
            lidx_reg <= '0;
            port_reg <= '0;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                cmp_reg[ch] <= '0;
                per_reg[ch] <= '0;
            end
        end
        else if (adv) begin
            tick_reg <= tick_next;
            en_reg   <= en_next;
            sidx_reg <= sidx_next;
            srev_reg <= srev_next;
            ridx_reg <= ridx_next;
            lidx_reg <= lidx_next;
            port_reg <= port_next;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                cmp_reg[ch] <= cmp_next[ch];
                per_reg[ch] <= per_next[ch];
            end
        end
    end

endmodule

// ----- hw/rtl/dual_stepper_timed_sequencer.sv -----
// Dual stepper timed sequencer: input register, compare core, result register.
//
// Usage: every request on cmd is either a timer tick (func = tick) or a
// command that arms one of three output-compare channels: straight (speed
// magnitude is the period, sign the direction), rotate right or rotate left
// (speed is the period). Each request yields exactly one result on res:
// the 8-bit stepper port after the request, whether any channel wrote it,
// and which channels fired on that tick.
// An accepted request waits in the input register; its result enters the
// result register once res is not stalled.
// Throughput: one request per clock unless res stalls, set by the single
// pass through the compare core between the input and result registers.
// Reset (rst_n low, asynchronous) clears the tick counter, compares,
// periods, enables, table indexes and the port to zero; all channels off.
// When res is stalled the result register holds, the input register takes
// one more request, and cmd.ready then drops until res.ready returns.
module dual_stepper_timed_sequencer #(
    parameter int TIMER_WIDTH = dsts_pkg::TIMER_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dsts_cmd_if.sink   cmd,
    dsts_res_if.source res
);
    import dsts_pkg::*;

    logic  in_valid_reg, in_valid_next;
    cmd_t  in_reg;
    logic  out_valid_reg, out_valid_next;
    res_t  out_reg;
    res_t  core_res;
    logic  adv;

    assign adv       = in_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !in_valid_reg || adv;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (cmd.ready) begin
            in_valid_next = cmd.valid;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv) begin
            out_valid_next = 1'b1;
        end
        else if (res.ready) begin
            out_valid_next = 1'b0;
        end
    end

    dsts_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .item   (in_reg),
        .result (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready) begin
            in_reg <= cmd.data;
        end
        if (adv) begin
            out_reg <= core_res;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;

    // commands never fire a channel
    a_cmd_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
        adv && (in_reg.func != FUNC_TICK) |=> out_reg.channels_fired == '0)
        else $error("command request reported a fired channel");

    // written flag matches the fired mask
    a_written_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.port_written == (out_reg.channels_fired != '0)))
        else $error("port_written disagrees with channels_fired");

    // a result with no write repeats the previous port value
    a_port_hold: assert property (@(posedge clk) disable iff (!rst_n)
        adv ##1 adv && !core_res.port_written
        |-> core_res.port_value == $past(core_res.port_value))
        else $error("port changed without a channel firing");

endmodule
